// ===== rtl/mbg_pkg.sv =====
// ----------------------------------------------------------------------------
// mbg_pkg: shared types and constants of the metronome beat generator
// Field widths, tempo and bar limits, reset values and the action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mbg_pkg;

    // Field widths
    localparam int ACTION_W = 3;
    localparam int DELTA_W  = 5;
    localparam int TEMPO_W  = 9;
    localparam int BAR_W    = 6;
    localparam int POS_W    = 5;
    localparam int CNT_W    = 16;

    // Legal ranges
    localparam int MAX_TEMPO = 500;
    localparam int MAX_BAR   = 32;

    // Milliseconds per minute, the dividend of the countdown reload on each strike
    localparam logic [CNT_W-1:0] MS_PER_MINUTE = CNT_W'(60000);

    // Reset values
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(80);
    localparam logic [BAR_W-1:0]   BAR_RESET   = BAR_W'(4);

    // Action codes
    typedef logic [ACTION_W-1:0] t_action;
    localparam t_action ACT_TICK   = 3'd0;
    localparam t_action ACT_TOGGLE = 3'd1;
    localparam t_action ACT_BAR    = 3'd2;
    localparam t_action ACT_TEMPO  = 3'd3;
    localparam t_action ACT_STOP   = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/metronome_beat_generator_top.sv =====
// ----------------------------------------------------------------------------
// metronome_beat_generator_top: metronome with bar accent
// Takes millisecond ticks and button events, emits one status transaction per
// input transaction with strike and accent flags.
// ----------------------------------------------------------------------------
// Every input transaction produces exactly one result, loaded into the output
// register in the cycle the transaction is accepted. A tick that sounds a
// strike also reloads the countdown with 60000 / tempo, computed by a
// restoring divider that settles one quotient bit per cycle, so such a tick
// keeps the input stalled until the divider is done. A new transaction is
// also held off while the previous result is still waiting in the output
// register and stalled.
`default_nettype none

module metronome_beat_generator_top
    import mbg_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // input channel
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire  [ACTION_W-1:0]       i_action,
    input  wire  signed [DELTA_W-1:0] i_delta,
    // output channel
    output logic                      o_valid,
    input  wire                       i_stall,
    output logic                      o_strike,
    output logic                      o_accent,
    output logic [TEMPO_W-1:0]        o_tempo_bpm,
    output logic [BAR_W-1:0]          o_beats_per_bar,
    output logic                      o_running
);

    localparam int DIV_CNT_W = $clog2(CNT_W);
    localparam int TSUM_W    = TEMPO_W + 2;
    localparam int BSUM_W    = BAR_W + 2;

    localparam logic signed [TSUM_W-1:0] TEMPO_LO = TSUM_W'(1);
    localparam logic signed [TSUM_W-1:0] TEMPO_HI = TSUM_W'(MAX_TEMPO);
    localparam logic signed [BSUM_W-1:0] BAR_LO   = BSUM_W'(0);
    localparam logic signed [BSUM_W-1:0] BAR_HI   = BSUM_W'(MAX_BAR);

    // Sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic                  r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [TEMPO_W-1:0]    r_rem, n_rem;
    logic [TEMPO_W-1:0]    r_tempo, n_tempo;
    logic [BAR_W-1:0]      r_bar, n_bar;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_active, n_active;
    logic [CNT_W-1:0]      r_countdown, n_countdown;

    logic                  r_out_valid, n_out_valid;
    logic                  r_strike, n_strike;
    logic                  r_accent, n_accent;

    logic                  accept;
    logic                  out_free;
    logic signed [TSUM_W-1:0] tempo_sum;
    logic signed [BSUM_W-1:0] bar_sum;
    logic [BAR_W-1:0]      pos_inc;
    logic [TEMPO_W:0]      trial;
    logic                  q_bit;

    // Take a transaction only when idle and the output register can be loaded
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;

    // Clamped adders and beat advance
    assign tempo_sum = $signed({2'b00, r_tempo})
                     + $signed({{(TSUM_W-DELTA_W){i_delta[DELTA_W-1]}}, i_delta});
    assign bar_sum   = $signed({2'b00, r_bar})
                     + $signed({{(BSUM_W-DELTA_W){i_delta[DELTA_W-1]}}, i_delta});
    assign pos_inc   = {1'b0, r_pos} + BAR_W'(1);

    // Divider step: shift one dividend bit in, subtract if it fits
    assign trial = {r_rem, MS_PER_MINUTE[r_div_cnt]};
    assign q_bit = (trial >= {1'b0, r_tempo});

    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        n_rem       = r_rem;
        n_tempo     = r_tempo;
        n_bar       = r_bar;
        n_pos       = r_pos;
        n_active    = r_active;
        n_countdown = r_countdown;
        n_strike    = r_strike;
        n_accent    = r_accent;
        n_out_valid = r_out_valid && i_stall;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strike = 1'b0;
                    n_accent = 1'b0;
                    unique case (i_action)
                        ACT_TICK: begin
                            if (r_active) begin
                                if (r_countdown <= CNT_W'(1)) begin
                                    n_strike = 1'b1;
                                    n_accent = (r_pos == '0) && (r_bar != '0);
                                    if (pos_inc >= r_bar) begin
                                        n_pos = '0;
                                    end else begin
                                        n_pos = pos_inc[POS_W-1:0];
                                    end
                                    // launch the countdown reload
                                    n_state     = S_DIV;
                                    n_div_cnt   = DIV_CNT_W'(CNT_W - 1);
                                    n_rem       = '0;
                                    n_countdown = '0;
                                end else begin
                                    n_countdown = r_countdown - CNT_W'(1);
                                end
                            end
                        end
                        ACT_TOGGLE: begin
                            if (r_active) begin
                                n_active    = 1'b0;
                                n_countdown = '0;
                            end else begin
                                n_pos       = '0;
                                n_active    = 1'b1;
                                n_countdown = CNT_W'(1);
                            end
                        end
                        ACT_BAR: begin
                            if (bar_sum < BAR_LO) begin
                                n_bar = '0;
                            end else if (bar_sum > BAR_HI) begin
                                n_bar = BAR_HI[BAR_W-1:0];
                            end else begin
                                n_bar = bar_sum[BAR_W-1:0];
                            end
                        end
                        ACT_TEMPO: begin
                            if (tempo_sum < TEMPO_LO) begin
                                n_tempo = TEMPO_LO[TEMPO_W-1:0];
                            end else if (tempo_sum > TEMPO_HI) begin
                                n_tempo = TEMPO_HI[TEMPO_W-1:0];
                            end else begin
                                n_tempo = tempo_sum[TEMPO_W-1:0];
                            end
                        end
                        ACT_STOP: begin
                            n_active    = 1'b0;
                            n_countdown = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_valid = 1'b1;
                end
            end
            S_DIV: begin
                // shift the quotient bit straight into the countdown
                if (q_bit) begin
                    n_rem = trial[TEMPO_W-1:0] - r_tempo;
                end else begin
                    n_rem = trial[TEMPO_W-1:0];
                end
                n_countdown = {r_countdown[CNT_W-2:0], q_bit};
                if (r_div_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_div_cnt = r_div_cnt - DIV_CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_tempo     <= TEMPO_RESET;
            r_bar       <= BAR_RESET;
            r_pos       <= '0;
            r_active    <= 1'b0;
            r_countdown <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_tempo     <= n_tempo;
            r_bar       <= n_bar;
            r_pos       <= n_pos;
            r_active    <= n_active;
            r_countdown <= n_countdown;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_strike <= n_strike;
        r_accent <= n_accent;
    end

    // Drive the output channel; status fields show the live state, which only
    // changes when the result register is loaded
    assign o_valid         = r_out_valid;
    assign o_strike        = r_strike;
    assign o_accent        = r_accent;
    assign o_tempo_bpm     = r_tempo;
    assign o_beats_per_bar = r_bar;
    assign o_running       = r_active;

endmodule

`default_nettype wire

// ===== rtl/mbg_checker.sv =====
// ----------------------------------------------------------------------------
// mbg_checker: port-level checks for the metronome beat generator
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mbg_checker
    import mbg_pkg::*;
(
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_valid,
    input wire                       o_stall,
    input wire  [ACTION_W-1:0]       i_action,
    input wire  signed [DELTA_W-1:0] i_delta,
    input wire                       o_valid,
    input wire                       i_stall,
    input wire                       o_strike,
    input wire                       o_accent,
    input wire  [TEMPO_W-1:0]        o_tempo_bpm,
    input wire  [BAR_W-1:0]          o_beats_per_bar,
    input wire                       o_running
);

    // Hold a stalled input transaction
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_action) && $stable(i_delta)))
        else $error("stalled input transaction changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_strike) && $stable(o_accent)
            && $stable(o_tempo_bpm) && $stable(o_beats_per_bar) && $stable(o_running)))
        else $error("stalled result changed");

    // Every accepted transaction shows a result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted transaction produced no result");

    // Accent only on a strike, and strikes only while running
    a_accent_strike: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_accent || o_strike)) |-> (o_strike && o_running))
        else $error("accent without strike or strike while stopped");

    // Reported tempo and bar length stay in range
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_tempo_bpm != '0) && (o_tempo_bpm <= TEMPO_W'(MAX_TEMPO))
            && (o_beats_per_bar <= BAR_W'(MAX_BAR))))
        else $error("tempo or bar length out of range");

endmodule

bind metronome_beat_generator_top mbg_checker u_mbg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_action        (i_action),
    .i_delta         (i_delta),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_strike        (o_strike),
    .o_accent        (o_accent),
    .o_tempo_bpm     (o_tempo_bpm),
    .o_beats_per_bar (o_beats_per_bar),
    .o_running       (o_running)
);

`default_nettype wire

// ===== verif/tb_metronome_beat_generator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_metronome_beat_generator_top: self-checking bench for the metronome
// Feeds ticks and button events over the input channel with random idle gaps
// and stalls the output channel at random. Each status transaction is checked
// field by field against a behavioral beat tracker that steps on every accepted input.
// ----------------------------------------------------------------------------

module tb_metronome_beat_generator_top;
    import mbg_pkg::*;

    // Actions the block has no use for
    localparam t_action ACT_SPARE_A = 3'd5;
    localparam t_action ACT_SPARE_C = 3'd7;

    localparam int RAND_ITEMS   = 400;  // counted random transactions
    localparam int RAND_STRIKES = 4;    // beats to reach in the random part
    localparam int QUIET_TAIL   = 150;  // no idling over the last items
    localparam int HOLD_START   = 600;  // cycles after reset
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo;
        logic [BAR_W-1:0]   bar_len;
        logic [POS_W-1:0]   beat_pos;
        logic               active;
        logic [CNT_W-1:0]   countdown;
    } t_metro_state;

    typedef struct packed {
        logic               strike;
        logic               accent;
        logic [TEMPO_W-1:0] tempo;
        logic [BAR_W-1:0]   bar_len;
        logic               running;
    } t_beat_status;

    typedef struct packed {
        t_action                   action;
        logic signed [DELTA_W-1:0] delta;
    } t_button_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [ACTION_W-1:0] i_action = '0;
    logic signed [DELTA_W-1:0] i_delta = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_strike;
    logic o_accent;
    logic [TEMPO_W-1:0] o_tempo_bpm;
    logic [BAR_W-1:0] o_beats_per_bar;
    logic o_running;

    t_button_item pending_q[$];
    t_beat_status status_q[$];
    t_metro_state gen_state;
    t_metro_state beat_model;

    int n_total = 0;
    int n_counted = 0;
    int n_gen_strikes = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int cycle_limit = 0;
    int cycle_cnt = 0;
    logic in_fire_q = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_clk = 0;
    int hold_left = 0;

    metronome_beat_generator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_delta        (i_delta),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_strike       (o_strike),
        .o_accent       (o_accent),
        .o_tempo_bpm    (o_tempo_bpm),
        .o_beats_per_bar(o_beats_per_bar),
        .o_running      (o_running)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_metro_state reset_state();
        t_metro_state st;
        st.tempo     = TEMPO_RESET;
        st.bar_len   = BAR_RESET;
        st.beat_pos  = '0;
        st.active    = 1'b0;
        st.countdown = '0;
        return st;
    endfunction

    function automatic int saturate_step(int cur, logic signed [DELTA_W-1:0] d,
                                         int lo, int hi);
        int s;
        s = cur + int'(d);
        if (s < lo) s = lo;
        if (s > hi) s = hi;
        return s;
    endfunction

    // Advance the beat tracker by one transaction and form its status
    function automatic void next_beat_state(input t_metro_state cur,
                                            input t_action act,
                                            input logic signed [DELTA_W-1:0] d,
                                            output t_metro_state nxt,
                                            output t_beat_status res);
        int pos;
        nxt = cur;
        res.strike = 1'b0;
        res.accent = 1'b0;
        case (act)
            ACT_TICK: begin
                if (cur.active) begin
                    if (cur.countdown <= 1) begin
                        res.strike = 1'b1;
                        res.accent = (cur.beat_pos == 0) && (cur.bar_len != 0);
                        pos = int'(cur.beat_pos) + 1;
                        if (pos >= int'(cur.bar_len)) pos = 0;
                        nxt.beat_pos  = POS_W'(pos);
                        nxt.countdown = CNT_W'(int'(MS_PER_MINUTE) / int'(cur.tempo));
                    end else begin
                        nxt.countdown = cur.countdown - 1'b1;
                    end
                end
            end
            ACT_TOGGLE: begin
                if (cur.active) begin
                    nxt.active    = 1'b0;
                    nxt.countdown = '0;
                end else begin
                    nxt.beat_pos  = '0;
                    nxt.active    = 1'b1;
                    nxt.countdown = CNT_W'(1);
                end
            end
            ACT_BAR:   nxt.bar_len = BAR_W'(saturate_step(cur.bar_len, d, 0, MAX_BAR));
            ACT_TEMPO: nxt.tempo = TEMPO_W'(saturate_step(cur.tempo, d, 1, MAX_TEMPO));
            ACT_STOP: begin
                nxt.active    = 1'b0;
                nxt.countdown = '0;
            end
            default: ;
        endcase
        res.tempo   = nxt.tempo;
        res.bar_len = nxt.bar_len;
        res.running = nxt.active;
    endfunction

    function automatic logic signed [DELTA_W-1:0] any_delta();
        return DELTA_W'($urandom_range(0, 31));
    endfunction

    // Append a transaction and track what it does for stimulus steering
    task automatic queue_item(input t_action act, input logic signed [DELTA_W-1:0] d);
        t_metro_state nxt;
        t_beat_status res;
        t_button_item it;
        it.action = act;
        it.delta  = d;
        pending_q = {pending_q, it};
        if (!((act == ACT_TICK && !gen_state.active) || act >= ACT_SPARE_A))
            n_counted++;
        next_beat_state(gen_state, act, d, nxt, res);
        gen_state = nxt;
        if (res.strike) n_gen_strikes++;
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("ERROR: result %0d %s: got %0d, expected %0d",
                     n_results, what, got, want);
    endtask

    // Check outgoing status, then step the tracker on incoming transactions
    always @(posedge i_clk) begin
        t_beat_status want;
        t_beat_status res;
        t_metro_state nxt;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (status_q.size() == 0) begin
                    flag_mismatch("with nothing pending", 1, 0);
                end else begin
                    want = status_q.pop_front();
                    if (o_strike !== want.strike)
                        flag_mismatch("strike", o_strike, want.strike);
                    if (o_accent !== want.accent)
                        flag_mismatch("accent", o_accent, want.accent);
                    if (o_tempo_bpm !== want.tempo)
                        flag_mismatch("tempo_bpm", o_tempo_bpm, want.tempo);
                    if (o_beats_per_bar !== want.bar_len)
                        flag_mismatch("beats_per_bar", o_beats_per_bar, want.bar_len);
                    if (o_running !== want.running)
                        flag_mismatch("running", o_running, want.running);
                end
                n_results++;
            end
            in_fire_q <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                next_beat_state(beat_model, t_action'(i_action), i_delta, nxt, res);
                beat_model = nxt;
                status_q = {status_q, res};
                n_accepted++;
            end
        end else begin
            in_fire_q <= 1'b0;
        end
    end

    // Driver: hold the offered transaction until taken, then idle or advance
    always @(negedge i_clk) begin
        t_button_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire_q) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_q.size() > 0) begin
                it = pending_q.pop_front();
                i_valid  <= 1'b1;
                i_action <= it.action;
                i_delta  <= it.delta;
                if (pending_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(1, 15);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted on its own clock count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            hold_clk <= hold_clk + 1;
            if (hold_clk == HOLD_START)
                hold_left <= HOLD_CYCLES;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // Receiver: random stall bursts, none over the tail of the run
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (pending_q.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_limit > 0 && cycle_cnt > cycle_limit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int run;
        int r;
        gen_state  = reset_state();
        beat_model = reset_state();

        // Directed: idle actions, spare codes, clamps, start/stop paths
        queue_item(ACT_TICK, 5'sd15);
        queue_item(ACT_STOP, -5'sd16);
        queue_item(ACT_SPARE_A, -5'sd16);
        queue_item(t_action'(3'd6), 5'sd15);
        queue_item(ACT_SPARE_C, 5'sd0);
        queue_item(ACT_BAR, -5'sd16);
        queue_item(ACT_BAR, 5'sd15);
        queue_item(ACT_BAR, 5'sd15);
        queue_item(ACT_BAR, 5'sd15);
        queue_item(ACT_BAR, -5'sd16);
        queue_item(ACT_BAR, -5'sd13);
        queue_item(ACT_TEMPO, 5'sd15);
        queue_item(ACT_TEMPO, -5'sd16);
        queue_item(ACT_TOGGLE, 5'sd0);
        queue_item(ACT_TICK, 5'sd0);
        queue_item(ACT_TOGGLE, 5'sd0);
        queue_item(ACT_TOGGLE, 5'sd0);
        queue_item(ACT_TICK, -5'sd1);
        queue_item(ACT_STOP, 5'sd0);
        queue_item(ACT_BAR, -5'sd16);
        queue_item(ACT_TOGGLE, 5'sd0);
        queue_item(ACT_TICK, 5'sd0);
        queue_item(ACT_TOGGLE, 5'sd0);
        queue_item(ACT_TICK, 5'sd0);

        // Random: settings, start, a run of ticks with stray events
        n_counted     = 0;
        n_gen_strikes = 0;
        while (n_counted < RAND_ITEMS || n_gen_strikes < RAND_STRIKES) begin
            if ($urandom_range(0, 19) == 0) begin
                // Dive to the lowest tempo, sound at most one beat, climb back
                repeat (36) queue_item(ACT_TEMPO, -5'sd16);
                if (!gen_state.active) queue_item(ACT_TOGGLE, any_delta());
                repeat ($urandom_range(1, 60)) queue_item(ACT_TICK, any_delta());
                queue_item(ACT_STOP, any_delta());
                repeat (36) queue_item(ACT_TEMPO, 5'sd15);
            end
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 1) == 0)
                    queue_item(ACT_BAR, any_delta());
                else if (gen_state.tempo < 300)
                    queue_item(ACT_TEMPO, DELTA_W'($urandom_range(5, 15)));
                else
                    queue_item(ACT_TEMPO, any_delta());
            end
            if (!gen_state.active) queue_item(ACT_TOGGLE, any_delta());
            run = $urandom_range(1, 40);
            repeat (run) begin
                r = $urandom_range(0, 99);
                if (r < 95)       queue_item(ACT_TICK, any_delta());
                else if (r < 97)  queue_item(ACT_BAR, any_delta());
                else if (r == 97) queue_item(ACT_TEMPO, any_delta());
                else if (r == 98) queue_item(ACT_TOGGLE, any_delta());
                else if ($urandom_range(0, 1) == 0) queue_item(ACT_STOP, any_delta());
                else queue_item(t_action'($urandom_range(ACT_SPARE_A, ACT_SPARE_C)),
                                any_delta());
            end
            if ($urandom_range(0, 3) == 0) begin
                queue_item($urandom_range(0, 1) ? ACT_STOP : ACT_TOGGLE, any_delta());
                queue_item(ACT_TICK, any_delta());
            end
        end

        n_total     = pending_q.size();
        cycle_limit = n_total * 300 + HOLD_CYCLES + 20000;

        // Hold reset, then release it away from the sampling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain and finish
        wait (n_accepted == n_total);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && status_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mbg_pkg.sv
rtl/metronome_beat_generator_top.sv
rtl/mbg_checker.sv
verif/tb_metronome_beat_generator_top.sv
